// File: hdl/eida_pkg.sv
package eida_pkg;

  // Operation codes of a request
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_ADD     = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_TEST    = 3'd4;

  // Status codes of a result
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_DUP    = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;  // sweep one mask entry to zero
    logic load;   // capture a request and issue the memory reads
    logic exec;   // finish the request and write back
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // the sweep is on its last entry
  } sts_t;

endpackage

// File: hdl/eida_ctrl.sv
module eida_ctrl
  import eida_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and result strobe
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Decode commands for the datapath
  assign cmd_o.clear = (state_q == S_CLEAR);
  assign cmd_o.load  = (state_q == S_IDLE) && start;
  assign cmd_o.exec  = (state_q == S_EXEC);

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: hdl/eida_dp.sv
module eida_dp
  import eida_pkg::*;
#(
  parameter int unsigned ENTITIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [2:0]  op_i,
  input  logic [10:0] entity_id_i,
  input  logic [4:0]  component_id_i,
  output logic [2:0]  status_o,
  output logic [9:0]  entity_out_o,
  output logic        bit_present_o,
  output logic [10:0] live_count_o
);

  localparam int IW = $clog2(ENTITIES);
  localparam int DW = $clog2(ENTITIES + 1);
  localparam int XW = (IW > 11) ? IW : 11;

  // Memories
  logic [IW-1:0] stack_mem [ENTITIES];
  logic [31:0]   mask_mem  [ENTITIES];

  // Control state
  logic [DW-1:0] depth_q, depth_d;
  logic [DW-1:0] low_q, low_d;
  logic [DW-1:0] live_q, live_d;
  logic [IW-1:0] clr_q;

  // Captured request and read data
  logic [2:0]    op_q;
  logic [10:0]   entity_id_q;
  logic [4:0]    cid_q;
  logic [IW-1:0] eid_idx_q;
  logic [IW-1:0] stack_rd_q;
  logic [31:0]   mask_rd_q;

  // Result registers
  logic [2:0]  status_q;
  logic [9:0]  ent_q;
  logic        present_q;
  logic [10:0] live_out_q;

  logic [XW-1:0] eid_x;
  logic [IW-1:0] eid_idx;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] rst_val;
  logic [IW-1:0] pop_id;
  logic          in_range;
  logic          bit_set;
  logic [2:0]    status_d;
  logic [9:0]    ent_d;
  logic          present_d;
  logic          push_we;
  logic          mask_op_we;
  logic [IW-1:0] mask_op_addr;
  logic [31:0]   mask_op_data;
  logic          mask_we;
  logic [IW-1:0] mask_waddr;
  logic [31:0]   mask_wdata;

  assign eid_x    = XW'(entity_id_i);
  assign eid_idx  = eid_x[IW-1:0];
  assign depth_m1 = depth_q - DW'(1);

  // An entry below the low-water mark was never pushed: it holds its reset value
  assign rst_val  = DW'(ENTITIES) - depth_q;
  assign pop_id   = (depth_q == low_q) ? rst_val[IW-1:0] : stack_rd_q;

  assign in_range = (32'(entity_id_q) < 32'(ENTITIES));
  assign bit_set  = mask_rd_q[cid_q];

  // Work out the result and the write-back
  always_comb begin
    depth_d      = depth_q;
    low_d        = low_q;
    live_d       = live_q;
    status_d     = ST_OK;
    ent_d        = entity_id_q[9:0];
    present_d    = 1'b0;
    push_we      = 1'b0;
    mask_op_we   = 1'b0;
    mask_op_addr = eid_idx_q;
    mask_op_data = '0;
    case (op_q)
      OP_CREATE: begin
        if (depth_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          depth_d      = depth_m1;
          if (depth_m1 < low_q) begin
            low_d = depth_m1;
          end
          ent_d        = 10'(pop_id);
          mask_op_we   = 1'b1;
          mask_op_addr = pop_id;
          live_d       = live_q + DW'(1);
        end
      end
      OP_DESTROY: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (depth_q == DW'(ENTITIES)) begin
          status_d = ST_FULL;
        end else begin
          push_we    = 1'b1;
          depth_d    = depth_q + DW'(1);
          mask_op_we = 1'b1;
          if (live_q != '0) begin
            live_d = live_q - DW'(1);
          end
        end
      end
      OP_ADD: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (bit_set) begin
          status_d = ST_DUP;
        end else begin
          mask_op_we   = 1'b1;
          mask_op_data = mask_rd_q | (32'd1 << cid_q);
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (!bit_set) begin
          status_d = ST_ABSENT;
        end else begin
          mask_op_we   = 1'b1;
          mask_op_data = mask_rd_q & ~(32'd1 << cid_q);
        end
      end
      OP_TEST: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          present_d = bit_set;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Share the mask write port between the sweep and requests
  assign mask_we    = cmd_i.clear || (cmd_i.exec && mask_op_we);
  assign mask_waddr = cmd_i.clear ? clr_q : mask_op_addr;
  assign mask_wdata = cmd_i.clear ? 32'd0 : mask_op_data;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DW'(ENTITIES);
      low_q   <= DW'(ENTITIES);
      live_q  <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + IW'(1);
      end
      if (cmd_i.exec) begin
        depth_q <= depth_d;
        low_q   <= low_d;
        live_q  <= live_d;
      end
    end
  end

  assign sts_o.clear_done = (clr_q == IW'(ENTITIES - 1));

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= op_i;
      entity_id_q <= entity_id_i;
      cid_q       <= component_id_i;
      eid_idx_q   <= eid_idx;
    end
  end

  // Free stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stack_rd_q <= stack_mem[depth_m1[IW-1:0]];
    end
    if (cmd_i.exec && push_we) begin
      stack_mem[depth_q[IW-1:0]] <= eid_idx_q;
    end
  end

  // Component mask memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_rd_q <= mask_mem[eid_idx];
    end
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q   <= status_d;
      ent_q      <= ent_d;
      present_q  <= present_d;
      live_out_q <= 11'(live_d);
    end
  end

  assign status_o      = status_q;
  assign entity_out_o  = ent_q;
  assign bit_present_o = present_q;
  assign live_count_o  = live_out_q;

endmodule

// File: hdl/entity_id_allocator_with_masks.sv
// Timing: a request taken at a clock edge moves the controller to S_EXEC, and its result,
// marked by done_o, is registered as S_EXEC ends; the receiver cannot stall.
// No new request is taken while a request is in S_EXEC, set by the registered read of the free stack
// and mask memories ahead of the write-back; a new request is taken while done_o shows.
// Reset: the stack is full and the count zero at once; busy then stays high while the mask
// memory is swept to zero, one entry a cycle.
module entity_id_allocator_with_masks
  import eida_pkg::*;
#(
  parameter int unsigned ENTITIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [10:0] entity_id_i,
  input  logic [4:0]  component_id_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [9:0]  entity_out_o,
  output logic        bit_present_o,
  output logic [10:0] live_count_o
);

  cmd_t cmd;
  sts_t sts;

  eida_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  eida_dp #(
    .ENTITIES (ENTITIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .entity_id_i    (entity_id_i),
    .component_id_i (component_id_i),
    .status_o       (status_o),
    .entity_out_o   (entity_out_o),
    .bit_present_o  (bit_present_o),
    .live_count_o   (live_count_o)
  );

endmodule

// File: tb/entity_id_allocator_with_masks_tb.sv
module entity_id_allocator_with_masks_tb;
  import eida_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENT         = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_REQS = 300;
  localparam int unsigned DRAIN_REQS  = 320;

  // Op codes the block treats as no operation
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [10:0] eid;
    logic [4:0]  cid;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [9:0]  entity_out;
    logic        bit_present;
    logic [10:0] live_count;
  } answer_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [2:0]  op_i           = '0;
  logic [10:0] entity_id_i    = '0;
  logic [4:0]  component_id_i = '0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [9:0]  entity_out_o;
  logic        bit_present_o;
  logic [10:0] live_count_o;

  // Predicted state of the allocator
  logic [9:0]  free_ids [ENT];
  int unsigned free_depth;
  logic [31:0] masks [ENT];
  int unsigned live_n;

  request_t    pending_reqs [$];
  answer_t     answer_q [$];
  answer_t     got_ans;
  int unsigned err_count = 0;
  int unsigned accepted  = 0;
  int unsigned gap_left  = 0;
  int unsigned gap_draw;
  int unsigned cycles    = 0;

  entity_id_allocator_with_masks #(.ENTITIES(ENT)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .entity_id_i    (entity_id_i),
    .component_id_i (component_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entity_out_o   (entity_out_o),
    .bit_present_o  (bit_present_o),
    .live_count_o   (live_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Work out the answer to one accepted request and advance the predicted state
  task automatic run_allocator(input request_t rq);
    answer_t     a;
    logic [31:0] bitm;
    bitm          = 32'h1 << rq.cid;
    a.status      = ST_OK;
    a.entity_out  = rq.eid[9:0];
    a.bit_present = 1'b0;
    case (rq.op)
      OP_CREATE: begin
        if (free_depth == 0) begin
          a.status = ST_EMPTY;
        end else begin
          free_depth--;
          a.entity_out        = free_ids[free_depth];
          masks[a.entity_out] = '0;
          live_n++;
        end
      end
      OP_DESTROY, OP_ADD, OP_REMOVE, OP_TEST: begin
        if (rq.eid >= ENT) begin
          a.status = ST_RANGE;
        end else begin
          case (rq.op)
            OP_DESTROY: begin
              if (free_depth >= ENT) begin
                a.status = ST_FULL;
              end else begin
                free_ids[free_depth] = rq.eid[9:0];
                free_depth++;
                masks[rq.eid] = '0;
                if (live_n > 0) live_n--;
              end
            end
            OP_ADD: begin
              if ((masks[rq.eid] & bitm) != 0) a.status = ST_DUP;
              else masks[rq.eid] = masks[rq.eid] | bitm;
            end
            OP_REMOVE: begin
              if ((masks[rq.eid] & bitm) == 0) a.status = ST_ABSENT;
              else masks[rq.eid] = masks[rq.eid] & ~bitm;
            end
            default: begin
              a.bit_present = (masks[rq.eid] & bitm) != 0;
            end
          endcase
        end
      end
      default: ;
    endcase
    a.live_count = live_n[10:0];
    answer_q.push_back(a);
  endtask

  task automatic queue_req(input logic [2:0] op, input logic [10:0] eid, input logic [4:0] cid);
    request_t rq;
    rq.op  = op;
    rq.eid = eid;
    rq.cid = cid;
    pending_reqs.push_back(rq);
  endtask

  // Mostly requests on a small set of low entity ids, with some noise over the full range
  function automatic request_t rand_request();
    request_t    rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      rq.op = OP_CREATE;
    else if (pick < 30) rq.op = OP_DESTROY;
    else if (pick < 55) rq.op = OP_ADD;
    else if (pick < 75) rq.op = OP_REMOVE;
    else if (pick < 95) rq.op = OP_TEST;
    else if (pick < 97) rq.op = OP_SPARE5;
    else if (pick < 99) rq.op = OP_SPARE6;
    else                rq.op = OP_SPARE7;
    pick = $urandom_range(0, 99);
    if (pick < 80)      rq.eid = 11'($urandom_range(0, 31));
    else if (pick < 90) rq.eid = 11'($urandom_range(0, ENT - 1));
    else                rq.eid = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 1) == 0) rq.cid = 5'($urandom_range(0, 3));
    else                           rq.cid = 5'($urandom_range(0, 31));
    return rq;
  endfunction

  // Drive requests: hold start until taken, then idle for a drawn gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        request_t done_rq;
        done_rq.op  = op_i;
        done_rq.eid = entity_id_i;
        done_rq.cid = component_id_i;
        run_allocator(done_rq);
        accepted++;
        // Every fourth stretch of 40 requests runs back to back
        gap_draw = ((accepted / 40) % 4 == 3) ? 0 : $urandom_range(0, 8);
        if (gap_draw == 0 && pending_reqs.size() > 0) begin
          done_rq        = pending_reqs.pop_front();
          op_i           <= done_rq.op;
          entity_id_i    <= done_rq.eid;
          component_id_i <= done_rq.cid;
        end else begin
          start    <= 1'b0;
          gap_left <= (gap_draw == 0) ? 0 : gap_draw - 1;
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          request_t nxt;
          nxt            = pending_reqs.pop_front();
          start          <= 1'b1;
          op_i           <= nxt.op;
          entity_id_i    <= nxt.eid;
          component_id_i <= nxt.cid;
        end
      end
    end
  end

  // Check each result against the oldest predicted answer
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        got_ans = answer_q.pop_front();
        if (status_o !== got_ans.status) begin
          $error("status: expected %0d, got %0d", got_ans.status, status_o);
          err_count++;
        end
        if (entity_out_o !== got_ans.entity_out) begin
          $error("entity_out: expected %0d, got %0d", got_ans.entity_out, entity_out_o);
          err_count++;
        end
        if (bit_present_o !== got_ans.bit_present) begin
          $error("bit_present: expected %0d, got %0d", got_ans.bit_present, bit_present_o);
          err_count++;
        end
        if (live_count_o !== got_ans.live_count) begin
          $error("live_count: expected %0d, got %0d", got_ans.live_count, live_count_o);
          err_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Predicted state after reset: full stack, id 0 on top
    for (int k = 0; k < ENT; k++) begin
      free_ids[k] = 10'(ENT - 1 - k);
      masks[k]    = '0;
    end
    free_depth = ENT;
    live_n     = 0;

    // Directed requests
    queue_req(OP_DESTROY, 11'd5, 5'd0);      // destroy on a full stack
    queue_req(OP_CREATE, 11'd0, 5'd0);
    queue_req(OP_CREATE, 11'd2047, 5'd31);
    queue_req(OP_CREATE, 11'd0, 5'd0);
    queue_req(OP_ADD, 11'd0, 5'd0);
    queue_req(OP_ADD, 11'd0, 5'd31);
    queue_req(OP_ADD, 11'd0, 5'd31);         // duplicate add
    queue_req(OP_TEST, 11'd0, 5'd31);
    queue_req(OP_TEST, 11'd0, 5'd7);
    queue_req(OP_REMOVE, 11'd0, 5'd7);       // remove of an absent bit
    queue_req(OP_REMOVE, 11'd0, 5'd31);
    queue_req(OP_ADD, 11'd1024, 5'd3);       // ids out of range
    queue_req(OP_DESTROY, 11'd2047, 5'd0);
    queue_req(OP_REMOVE, 11'd1500, 5'd0);
    queue_req(OP_TEST, 11'd1024, 5'd31);
    queue_req(OP_ADD, 11'd1, 5'd9);
    queue_req(OP_DESTROY, 11'd1, 5'd0);
    queue_req(OP_CREATE, 11'd0, 5'd0);       // reuses id 1 with a cleared mask
    queue_req(OP_TEST, 11'd1, 5'd9);
    queue_req(OP_DESTROY, 11'd1023, 5'd0);   // destroy of an entity that is not live
    queue_req(OP_DESTROY, 11'd900, 5'd0);
    queue_req(OP_DESTROY, 11'd901, 5'd0);
    queue_req(OP_DESTROY, 11'd902, 5'd0);    // live count held at zero
    queue_req(OP_SPARE5, 11'd2047, 5'd31);
    queue_req(OP_SPARE6, 11'd1023, 5'd0);
    queue_req(OP_SPARE7, 11'd0, 5'd31);
    queue_req(OP_TEST, 11'd1023, 5'd0);

    // Build up a large pool of live entities, with some mask traffic mixed in
    for (int n = 0; n < DRAIN_REQS; n++) begin
      if (n % 8 == 7)
        queue_req(OP_ADD, 11'($urandom_range(0, ENT - 1)), 5'($urandom_range(0, 31)));
      else
        queue_req(OP_CREATE, 11'($urandom_range(0, 2047)), 5'($urandom_range(0, 31)));
    end

    for (int n = 0; n < RANDOM_REQS; n++) pending_reqs.push_back(rand_request());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last answer, then let the pipeline settle
    while (pending_reqs.size() > 0 || start || answer_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/eida_pkg.sv
hdl/eida_ctrl.sv
hdl/eida_dp.sv
hdl/entity_id_allocator_with_masks.sv
tb/entity_id_allocator_with_masks_tb.sv
